/* rtl/core/jsu_pkg.sv */
// ============================================================================
// jsu_pkg
// Types, codes and a helper function shared by the JSON string unescaper.
// ============================================================================
package jsu_pkg;

    localparam int unsigned CharWidth   = 21;
    localparam int unsigned PosWidth    = 16;
    localparam int unsigned StatusWidth = 4;
    localparam int unsigned HexWidth    = 16;
    localparam int unsigned CountWidth  = 3;
    localparam int unsigned PhaseWidth  = 3;
    localparam int unsigned ByteWidth   = 8;

    localparam longint unsigned MAX_LEN = 64'd65535;
    localparam logic [PosWidth-1:0] PosLimit =
        (MAX_LEN < 64'd65535) ? PosWidth'(MAX_LEN) : 16'hFFFF;

    localparam logic [PhaseWidth-1:0] PH_AWAIT  = 3'd0;
    localparam logic [PhaseWidth-1:0] PH_BODY   = 3'd1;
    localparam logic [PhaseWidth-1:0] PH_ESC    = 3'd2;
    localparam logic [PhaseWidth-1:0] PH_HEX    = 3'd3;
    localparam logic [PhaseWidth-1:0] PH_HEXBAD = 3'd4;

    localparam logic [StatusWidth-1:0] ST_UNIT      = 4'd0;
    localparam logic [StatusWidth-1:0] ST_COMPLETE  = 4'd1;
    localparam logic [StatusWidth-1:0] ST_ENDED     = 4'd2;
    localparam logic [StatusWidth-1:0] ST_EMPTY     = 4'd3;
    localparam logic [StatusWidth-1:0] ST_ESC_CUT   = 4'd4;
    localparam logic [StatusWidth-1:0] ST_HEX_SHORT = 4'd5;
    localparam logic [StatusWidth-1:0] ST_NON_HEX   = 4'd6;
    localparam logic [StatusWidth-1:0] ST_ZERO_CODE = 4'd7;
    localparam logic [StatusWidth-1:0] ST_UNKNOWN   = 4'd8;

    localparam logic [CharWidth-1:0] CH_QUOTE  = 21'h22;
    localparam logic [CharWidth-1:0] CH_BSLASH = 21'h5C;
    localparam logic [CharWidth-1:0] CH_SLASH  = 21'h2F;
    localparam logic [CharWidth-1:0] CH_B      = 21'h62;
    localparam logic [CharWidth-1:0] CH_F      = 21'h66;
    localparam logic [CharWidth-1:0] CH_N      = 21'h6E;
    localparam logic [CharWidth-1:0] CH_R      = 21'h72;
    localparam logic [CharWidth-1:0] CH_T      = 21'h74;
    localparam logic [CharWidth-1:0] CH_U      = 21'h75;

    localparam logic [CharWidth-1:0] CODE_BS  = 21'd8;
    localparam logic [CharWidth-1:0] CODE_FF  = 21'd12;
    localparam logic [CharWidth-1:0] CODE_LF  = 21'd10;
    localparam logic [CharWidth-1:0] CODE_CR  = 21'd13;
    localparam logic [CharWidth-1:0] CODE_TAB = 21'd9;

    localparam logic [ByteWidth-1:0] UTF_LEAD2 = 8'hC0;
    localparam logic [ByteWidth-1:0] UTF_LEAD3 = 8'hE0;
    localparam logic [ByteWidth-1:0] UTF_CONT  = 8'h80;

    typedef struct packed {
        logic [CharWidth-1:0] char_code;
        logic                 end_mark;
    } jsu_item_t;

    typedef struct packed {
        logic [1:0]             cnt;
        logic [CharWidth-1:0]   val0;
        logic [ByteWidth-1:0]   val1;
        logic [ByteWidth-1:0]   val2;
        logic [PosWidth-1:0]    pos;
        logic [StatusWidth-1:0] status;
    } jsu_burst_t;

    // Bit 4 flags a valid hex digit, bits 3:0 carry its value.
    function automatic logic [4:0] hex_digit(input logic [CharWidth-1:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c inside {[21'h30:21'h39]}) begin
            r = {1'b1, c[3:0]};
        end else if (c inside {[21'h61:21'h66], [21'h41:21'h46]}) begin
            r = {1'b1, 4'(c[3:0] + 4'd9)};
        end
        return r;
    endfunction

endpackage

/* rtl/core/jsu_in_stage.sv */
// ============================================================================
// jsu_in_stage
// Input register that holds one accepted character until the decoder takes it.
// ============================================================================
module jsu_in_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  jsu_pkg::jsu_item_t  s_item,
    input  logic                take,
    output logic                item_valid,
    output jsu_pkg::jsu_item_t  item
);
    import jsu_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    jsu_item_t item_reg;

    assign s_tready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_tready) begin
            valid_next = s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg <= s_item;
        end
    end

endmodule

/* rtl/core/jsu_decode.sv */
// ============================================================================
// jsu_decode
// String state and escape decoding; turns one character into up to three
// results.
// ============================================================================
module jsu_decode (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                take,
    input  jsu_pkg::jsu_item_t  item,
    output jsu_pkg::jsu_burst_t burst
);
    import jsu_pkg::*;

    logic [PhaseWidth-1:0] phase_reg;
    logic [PhaseWidth-1:0] phase_next;
    logic [HexWidth-1:0]   hex_value_reg;
    logic [HexWidth-1:0]   hex_value_next;
    logic [CountWidth-1:0] hex_count_reg;
    logic [CountWidth-1:0] hex_count_next;
    logic [PosWidth-1:0]   position_reg;
    logic [PosWidth-1:0]   position_next;

    logic [4:0]            digit;
    logic [HexWidth-1:0]   hex_shift;
    logic [CountWidth-1:0] hex_inc;
    logic [PosWidth-1:0]   pos_inc;
    logic                  bad;

    assign digit     = hex_digit(item.char_code);
    assign hex_shift = {hex_value_reg[HexWidth-5:0], digit[3:0]};
    assign hex_inc   = hex_count_reg + 3'd1;
    assign pos_inc   = (position_reg < PosLimit) ? position_reg + 16'd1 : position_reg;
    assign bad       = (phase_reg == PH_HEXBAD) || !digit[4];

    always_comb begin
        phase_next     = phase_reg;
        hex_value_next = hex_value_reg;
        hex_count_next = hex_count_reg;
        position_next  = position_reg;
        burst.cnt      = 2'd0;
        burst.val0     = '0;
        burst.val1     = '0;
        burst.val2     = '0;
        burst.pos      = position_reg;
        burst.status   = ST_UNIT;

        if (item.end_mark) begin
            burst.cnt = 2'd1;
            case (phase_reg)
                PH_AWAIT: burst.status = ST_EMPTY;
                PH_BODY:  burst.status = ST_ENDED;
                PH_ESC:   burst.status = ST_ESC_CUT;
                default:  burst.status = ST_HEX_SHORT;
            endcase
            phase_next     = PH_AWAIT;
            hex_value_next = '0;
            hex_count_next = '0;
            position_next  = '0;
        end else begin
            position_next = pos_inc;
            case (phase_reg)
                PH_AWAIT: begin
                    phase_next = PH_BODY;
                end
                PH_BODY: begin
                    burst.cnt = 2'd1;
                    if (item.char_code == CH_QUOTE) begin
                        burst.status   = ST_COMPLETE;
                        phase_next     = PH_AWAIT;
                        hex_value_next = '0;
                        hex_count_next = '0;
                        position_next  = '0;
                    end else if (item.char_code == CH_BSLASH) begin
                        burst.cnt  = 2'd0;
                        phase_next = PH_ESC;
                    end else begin
                        burst.val0 = item.char_code;
                    end
                end
                PH_ESC: begin
                    burst.cnt  = 2'd1;
                    phase_next = PH_BODY;
                    case (item.char_code)
                        CH_QUOTE, CH_BSLASH, CH_SLASH: burst.val0 = item.char_code;
                        CH_B: burst.val0 = CODE_BS;
                        CH_F: burst.val0 = CODE_FF;
                        CH_N: burst.val0 = CODE_LF;
                        CH_R: burst.val0 = CODE_CR;
                        CH_T: burst.val0 = CODE_TAB;
                        CH_U: begin
                            burst.cnt      = 2'd0;
                            phase_next     = PH_HEX;
                            hex_value_next = '0;
                            hex_count_next = '0;
                        end
                        default: begin
                            burst.status   = ST_UNKNOWN;
                            phase_next     = PH_AWAIT;
                            hex_value_next = '0;
                            hex_count_next = '0;
                            position_next  = '0;
                        end
                    endcase
                end
                default: begin
                    phase_next     = bad ? PH_HEXBAD : PH_HEX;
                    hex_count_next = hex_inc;
                    if (digit[4]) begin
                        hex_value_next = hex_shift;
                    end
                    if (hex_inc[2]) begin
                        if (bad || hex_shift == '0) begin
                            burst.cnt      = 2'd1;
                            burst.status   = bad ? ST_NON_HEX : ST_ZERO_CODE;
                            phase_next     = PH_AWAIT;
                            position_next  = '0;
                        end else if (hex_shift[15:7] == '0) begin
                            burst.cnt  = 2'd1;
                            burst.val0 = CharWidth'(hex_shift[6:0]);
                            phase_next = PH_BODY;
                        end else if (hex_shift[15:11] == '0) begin
                            burst.cnt  = 2'd2;
                            burst.val0 = CharWidth'(UTF_LEAD2 | {3'b000, hex_shift[10:6]});
                            burst.val1 = UTF_CONT | {2'b00, hex_shift[5:0]};
                            phase_next = PH_BODY;
                        end else begin
                            burst.cnt  = 2'd3;
                            burst.val0 = CharWidth'(UTF_LEAD3 | {4'b0000, hex_shift[15:12]});
                            burst.val1 = UTF_CONT | {2'b00, hex_shift[11:6]};
                            burst.val2 = UTF_CONT | {2'b00, hex_shift[5:0]};
                            phase_next = PH_BODY;
                        end
                        hex_value_next = '0;
                        hex_count_next = '0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_AWAIT;
            hex_value_reg <= '0;
            hex_count_reg <= '0;
            position_reg  <= '0;
        end else if (take) begin
            phase_reg     <= phase_next;
            hex_value_reg <= hex_value_next;
            hex_count_reg <= hex_count_next;
            position_reg  <= position_next;
        end
    end

endmodule

/* rtl/core/jsu_out_burst.sv */
// ============================================================================
// jsu_out_burst
// Result register that holds the results of one character and hands them out
// one transfer at a time.
// ============================================================================
module jsu_out_burst (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          take,
    input  jsu_pkg::jsu_burst_t           burst,
    output logic                          free,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [jsu_pkg::CharWidth-1:0] unit_value,
    output logic [jsu_pkg::PosWidth-1:0]  source_pos,
    output logic [jsu_pkg::StatusWidth-1:0] status,
    output logic                          m_tlast
);
    import jsu_pkg::*;

    logic [1:0]             cnt_reg;
    logic [1:0]             cnt_next;
    logic [CharWidth-1:0]   val0_reg;
    logic [ByteWidth-1:0]   val1_reg;
    logic [ByteWidth-1:0]   val2_reg;
    logic [PosWidth-1:0]    pos_reg;
    logic [StatusWidth-1:0] status_reg;
    logic                   shift;

    assign m_tvalid   = cnt_reg != 2'd0;
    assign m_tlast    = cnt_reg == 2'd1;
    assign free       = (cnt_reg == 2'd0) || (m_tlast && m_tready);
    assign shift      = m_tvalid && m_tready;
    assign unit_value = val0_reg;
    assign source_pos = pos_reg;
    assign status     = status_reg;

    always_comb begin
        cnt_next = cnt_reg;
        if (take) begin
            cnt_next = burst.cnt;
        end else if (shift) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            val0_reg   <= burst.val0;
            val1_reg   <= burst.val1;
            val2_reg   <= burst.val2;
            pos_reg    <= burst.pos;
            status_reg <= burst.status;
        end else if (shift) begin
            val0_reg <= CharWidth'(val1_reg);
            val1_reg <= val2_reg;
        end
    end

endmodule

/* rtl/core/json_string_unescape.sv */
// ============================================================================
// json_string_unescape
// Decodes quoted JSON string literals, one source character per transfer.
// ============================================================================
// The slave channel takes one character per transfer in s_tdata, or an end
// mark flagged in s_tuser. The first character of a string is its opening
// delimiter and is dropped. Each result on the master channel carries a
// decoded character or UTF-8 byte with its source position in m_tdata and a
// status code in m_tuser; m_tlast marks the last result of one character.
// A closing quote, an end mark or an error gives one status result, and the
// next character then opens a new string.
// A character passes the input register and then the decode and result
// register, from which its first result is presented. One character is
// taken per cycle while the master side keeps up; a \u escape giving two
// or three UTF-8 bytes holds the decoder while the result register
// drains.
// When the master side stalls, the input register can still take one
// character, and s_tready then stays low until the result register frees.
// Reset empties both registers and puts the decoder back to waiting for an
// opening delimiter.
// ============================================================================
module json_string_unescape (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // char_code [20:0], zero [23:21]
    input  logic        s_tuser,   // end_mark
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // unit_value [20:0], source_pos [36:21], zero
    output logic [3:0]  m_tuser,   // status
    output logic        m_tlast    // last_of_run
);
    import jsu_pkg::*;

    jsu_item_t              s_item;
    jsu_item_t              item;
    jsu_burst_t             burst;
    logic                   item_valid;
    logic                   free;
    logic                   take;
    logic [CharWidth-1:0]   unit_value;
    logic [PosWidth-1:0]    source_pos;
    logic [StatusWidth-1:0] status;

    assign s_item.char_code = s_tdata[CharWidth-1:0];
    assign s_item.end_mark  = s_tuser;
    assign take             = item_valid && free;
    assign m_tdata          = {3'b000, source_pos, unit_value};
    assign m_tuser          = status;

    jsu_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    jsu_decode u_dec (
        .aclk    (aclk),
        .aresetn (aresetn),
        .take    (take),
        .item    (item),
        .burst   (burst)
    );

    jsu_out_burst u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .take       (take),
        .burst      (burst),
        .free       (free),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .unit_value (unit_value),
        .source_pos (source_pos),
        .status     (status),
        .m_tlast    (m_tlast)
    );

    a_status_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != ST_UNIT |-> m_tlast)
        else $error("status result is not the last of its run");

    a_status_no_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != ST_UNIT |-> m_tdata[20:0] == '0)
        else $error("status result carries a value");

    a_burst_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("UTF-8 sequence interrupted");

    a_take_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        take |-> !m_tvalid || (m_tlast && m_tready))
        else $error("decoder loaded over pending results");

endmodule

/* tb/json_string_unescape_test.sv */
// ============================================================================
// json_string_unescape_test
// Self-checking test of the JSON string unescaper. Directed strings cover
// the empty input, extreme code points, UTF-8 output of each length and
// every error status. Random well-formed strings with random errors and
// noise follow. Both channels idle at random except during one back-to-back
// stretch. A predictor decodes every accepted transfer, and each result
// transfer is checked field by field against the oldest predicted result.
// ============================================================================
module json_string_unescape_test;

    timeunit 1ns;
    timeprecision 1ps;

    import jsu_pkg::*;

    localparam logic [CharWidth-1:0] DIGIT_ZERO  = 21'h30;
    localparam logic [CharWidth-1:0] DIGIT_NINE  = 21'h39;
    localparam logic [CharWidth-1:0] HEX_LOWER_A = 21'h61;
    localparam logic [CharWidth-1:0] HEX_LOWER_F = 21'h66;
    localparam logic [CharWidth-1:0] HEX_UPPER_A = 21'h41;
    localparam logic [CharWidth-1:0] HEX_UPPER_F = 21'h46;
    localparam logic [CharWidth-1:0] ASCII_SPACE = 21'h20;
    localparam logic [CharWidth-1:0] ASCII_TILDE = 21'h7E;
    localparam logic [CharWidth-1:0] LETTER_A    = 21'h61;
    localparam logic [CharWidth-1:0] LETTER_X    = 21'h78;
    localparam logic [CharWidth-1:0] CODE_MAX    = 21'h10FFFF;
    localparam logic [HexWidth-1:0]  ONE_BYTE_MAX = 16'h007F;
    localparam logic [HexWidth-1:0]  TWO_BYTE_MAX = 16'h07FF;
    localparam int IDLE_PERCENT   = 24;
    localparam int RANDOM_ITEMS   = 470;
    localparam int DRAIN_CYCLES   = 12;
    localparam int MAX_REPORTS    = 40;

    typedef struct packed {
        logic [CharWidth-1:0]   value;
        logic [PosWidth-1:0]    pos;
        logic [StatusWidth-1:0] status;
        logic                   last;
    } unit_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;     // char_code [20:0], zero [23:21]
    logic        s_tuser  = 1'b0;   // end_mark
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;           // unit_value [20:0], source_pos [36:21], zero
    logic [3:0]  m_tuser;           // status
    logic        m_tlast;           // last_of_run

    // Predictor state.
    logic [PhaseWidth-1:0] str_phase  = PH_AWAIT;
    logic [HexWidth-1:0]   hex_acc    = '0;
    int                    hex_seen   = 0;
    logic [PosWidth-1:0]   char_index = '0;

    unit_t expected_units[$];
    int    mismatches    = 0;
    int    items_sent    = 0;
    int    strings_sent  = 0;
    int    units_checked = 0;
    bit    no_idle       = 1'b0;

    json_string_unescape dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    function automatic int hex_nibble(input logic [CharWidth-1:0] c);
        if (c >= DIGIT_ZERO && c <= DIGIT_NINE) return int'(c - DIGIT_ZERO);
        if (c >= HEX_LOWER_A && c <= HEX_LOWER_F) return int'(c - HEX_LOWER_A) + 10;
        if (c >= HEX_UPPER_A && c <= HEX_UPPER_F) return int'(c - HEX_UPPER_A) + 10;
        return -1;
    endfunction

    function automatic logic [CharWidth-1:0] hex_char(input logic [3:0] n, input bit upper);
        if (n < 4'd10) return DIGIT_ZERO + CharWidth'(n);
        return (upper ? HEX_UPPER_A : HEX_LOWER_A) + CharWidth'(n - 4'd10);
    endfunction

    function automatic void restart_string();
        str_phase  = PH_AWAIT;
        hex_acc    = '0;
        hex_seen   = 0;
        char_index = '0;
    endfunction

    // Works out the results of one accepted character or end mark.
    function automatic void decode_char(input logic [CharWidth-1:0] c, input logic end_mark);
        unit_t                  batch[$];
        logic [PosWidth-1:0]    idx;
        logic [StatusWidth-1:0] st;
        logic [CharWidth-1:0]   code;
        int                     d;
        idx = char_index;
        if (end_mark) begin
            case (str_phase)
                PH_AWAIT: st = ST_EMPTY;
                PH_BODY:  st = ST_ENDED;
                PH_ESC:   st = ST_ESC_CUT;
                default:  st = ST_HEX_SHORT;
            endcase
            batch.insert(batch.size(), '{'0, idx, st, 1'b0});
            restart_string();
        end else begin
            if (char_index < PosLimit) char_index = char_index + 1'b1;
            case (str_phase)
                PH_AWAIT: begin
                    str_phase = PH_BODY;
                end
                PH_BODY: begin
                    if (c == CH_QUOTE) begin
                        batch.insert(batch.size(), '{'0, idx, ST_COMPLETE, 1'b0});
                        restart_string();
                    end else if (c == CH_BSLASH) begin
                        str_phase = PH_ESC;
                    end else begin
                        batch.insert(batch.size(), '{c, idx, ST_UNIT, 1'b0});
                    end
                end
                PH_ESC: begin
                    code = '0;
                    case (c)
                        CH_QUOTE, CH_BSLASH, CH_SLASH: code = c;
                        CH_B: code = CODE_BS;
                        CH_F: code = CODE_FF;
                        CH_N: code = CODE_LF;
                        CH_R: code = CODE_CR;
                        CH_T: code = CODE_TAB;
                        CH_U: begin
                            str_phase = PH_HEX;
                            hex_acc   = '0;
                            hex_seen  = 0;
                        end
                        default: begin
                            batch.insert(batch.size(), '{'0, idx, ST_UNKNOWN, 1'b0});
                            restart_string();
                        end
                    endcase
                    if (str_phase == PH_ESC) begin
                        batch.insert(batch.size(), '{code, idx, ST_UNIT, 1'b0});
                        str_phase = PH_BODY;
                    end
                end
                default: begin
                    d = hex_nibble(c);
                    if (d < 0) str_phase = PH_HEXBAD;
                    else hex_acc = {hex_acc[11:0], 4'(d)};
                    hex_seen++;
                    if (hex_seen == 4) begin
                        if (str_phase == PH_HEXBAD) begin
                            batch.insert(batch.size(), '{'0, idx, ST_NON_HEX, 1'b0});
                            restart_string();
                        end else if (hex_acc == '0) begin
                            batch.insert(batch.size(), '{'0, idx, ST_ZERO_CODE, 1'b0});
                            restart_string();
                        end else begin
                            if (hex_acc <= ONE_BYTE_MAX) begin
                                batch.insert(batch.size(),
                                             '{CharWidth'(hex_acc), idx, ST_UNIT, 1'b0});
                            end else if (hex_acc <= TWO_BYTE_MAX) begin
                                batch.insert(batch.size(),
                                    '{CharWidth'(UTF_LEAD2 | ByteWidth'(hex_acc[10:6])),
                                      idx, ST_UNIT, 1'b0});
                                batch.insert(batch.size(),
                                    '{CharWidth'(UTF_CONT | ByteWidth'(hex_acc[5:0])),
                                      idx, ST_UNIT, 1'b0});
                            end else begin
                                batch.insert(batch.size(),
                                    '{CharWidth'(UTF_LEAD3 | ByteWidth'(hex_acc[15:12])),
                                      idx, ST_UNIT, 1'b0});
                                batch.insert(batch.size(),
                                    '{CharWidth'(UTF_CONT | ByteWidth'(hex_acc[11:6])),
                                      idx, ST_UNIT, 1'b0});
                                batch.insert(batch.size(),
                                    '{CharWidth'(UTF_CONT | ByteWidth'(hex_acc[5:0])),
                                      idx, ST_UNIT, 1'b0});
                            end
                            str_phase = PH_BODY;
                            hex_acc   = '0;
                            hex_seen  = 0;
                        end
                    end
                end
            endcase
        end
        if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
        expected_units = {expected_units, batch};
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatches < MAX_REPORTS) $display("MISMATCH at %0t ns: %s", $time, what);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        m_tready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) decode_char(s_tdata[CharWidth-1:0], s_tuser);
    end

    always @(posedge aclk) begin : check_results
        unit_t want;
        if (aresetn && m_tvalid && m_tready) begin
            units_checked++;
            if (expected_units.size() == 0) begin
                report_mismatch($sformatf("unexpected result value=%h status=%0d",
                                          m_tdata[20:0], m_tuser));
            end else begin
                want = expected_units.pop_front();
                if (m_tdata[20:0] != want.value)
                    report_mismatch($sformatf("unit_value %h, expected %h",
                                              m_tdata[20:0], want.value));
                if (m_tdata[36:21] != want.pos)
                    report_mismatch($sformatf("source_pos %0d, expected %0d",
                                              m_tdata[36:21], want.pos));
                if (m_tuser != want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              m_tuser, want.status));
                if (m_tlast != want.last)
                    report_mismatch($sformatf("last_of_run %b, expected %b",
                                              m_tlast, want.last));
            end
        end
    end

    task automatic send_item(input logic [CharWidth-1:0] code, input logic end_mark);
        while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, code};
        s_tuser  <= end_mark;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic send_end();
        send_item(CharWidth'($urandom_range(CODE_MAX)), 1'b1);
    endtask

    task automatic send_unicode_escape(input logic [HexWidth-1:0] u);
        send_item(CH_BSLASH, 1'b0);
        send_item(CH_U, 1'b0);
        for (int i = 3; i >= 0; i--)
            send_item(hex_char(u[i*4 +: 4], 1'($urandom_range(1))), 1'b0);
    endtask

    function automatic logic [CharWidth-1:0] pick_plain();
        logic [CharWidth-1:0] c;
        int                   r;
        c = CH_QUOTE;
        while (c == CH_QUOTE || c == CH_BSLASH) begin
            r = $urandom_range(99);
            if (r < 60) c = CharWidth'($urandom_range(ASCII_TILDE, ASCII_SPACE));
            else if (r < 80) c = CharWidth'($urandom_range(TWO_BYTE_MAX));
            else c = CharWidth'($urandom_range(CODE_MAX));
        end
        return c;
    endfunction

    function automatic logic [CharWidth-1:0] pick_non_hex();
        logic [CharWidth-1:0] c;
        c = DIGIT_ZERO;
        while (hex_nibble(c) >= 0) begin
            case ($urandom_range(2))
                0: c = CH_QUOTE;
                1: c = CharWidth'($urandom_range(ASCII_TILDE, ASCII_SPACE));
                default: c = CharWidth'($urandom_range(CODE_MAX));
            endcase
        end
        return c;
    endfunction

    function automatic logic [CharWidth-1:0] pick_escape_letter();
        case ($urandom_range(7))
            0: return CH_QUOTE;
            1: return CH_BSLASH;
            2: return CH_SLASH;
            3: return CH_B;
            4: return CH_F;
            5: return CH_N;
            6: return CH_R;
            default: return CH_T;
        endcase
    endfunction

    function automatic logic [HexWidth-1:0] pick_code_unit();
        case ($urandom_range(2))
            0: return HexWidth'($urandom_range(ONE_BYTE_MAX, 1));
            1: return HexWidth'($urandom_range(TWO_BYTE_MAX, ONE_BYTE_MAX + 1));
            default: return HexWidth'($urandom_range(16'hFFFF, TWO_BYTE_MAX + 1));
        endcase
    endfunction

    // One string: random delimiter, random body, then a random way of ending; now and then only an end mark.
    task automatic send_random_string();
        logic [CharWidth-1:0] c;
        int                   body_len;
        int                   ending;
        int                   k;
        int                   bad_at;
        strings_sent++;
        if ($urandom_range(99) < 4) begin
            send_end();
            return;
        end
        send_item(CharWidth'($urandom_range(CODE_MAX)), 1'b0);
        body_len = $urandom_range(10);
        repeat (body_len) begin
            k = $urandom_range(99);
            if (k < 45) begin
                send_item(pick_plain(), 1'b0);
            end else if (k < 65) begin
                send_item(CH_BSLASH, 1'b0);
                send_item(pick_escape_letter(), 1'b0);
            end else begin
                send_unicode_escape(pick_code_unit());
            end
        end
        ending = $urandom_range(99);
        if (ending < 66) begin
            send_item(CH_QUOTE, 1'b0);
        end else if (ending < 72) begin
            send_end();
        end else if (ending < 76) begin
            send_item(CH_BSLASH, 1'b0);
            send_end();
        end else if (ending < 82) begin
            send_item(CH_BSLASH, 1'b0);
            send_item(CH_U, 1'b0);
            k = $urandom_range(3);
            for (int i = 0; i < k; i++) begin
                if ($urandom_range(3) == 0) send_item(pick_non_hex(), 1'b0);
                else send_item(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))), 1'b0);
            end
            send_end();
        end else if (ending < 88) begin
            send_item(CH_BSLASH, 1'b0);
            send_item(CH_U, 1'b0);
            bad_at = $urandom_range(3);
            for (int i = 0; i < 4; i++) begin
                if (i == bad_at || $urandom_range(4) == 0) send_item(pick_non_hex(), 1'b0);
                else send_item(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))), 1'b0);
            end
        end else if (ending < 93) begin
            send_unicode_escape('0);
        end else begin
            send_item(CH_BSLASH, 1'b0);
            c = CH_QUOTE;
            while (c == CH_QUOTE || c == CH_BSLASH || c == CH_SLASH || c == CH_B ||
                   c == CH_F || c == CH_N || c == CH_R || c == CH_T || c == CH_U)
                c = ($urandom_range(1) == 0) ? CharWidth'($urandom_range(ASCII_TILDE, ASCII_SPACE))
                                             : CharWidth'($urandom_range(CODE_MAX));
            send_item(c, 1'b0);
        end
    endtask

    task automatic test_empty_input();
        strings_sent++;
        send_item(CODE_MAX, 1'b1);
    endtask

    task automatic test_plain_and_unicode();
        strings_sent += 2;
        send_item(CODE_MAX, 1'b0);
        send_item(CODE_MAX, 1'b0);
        send_item('0, 1'b0);
        send_item(CH_BSLASH, 1'b0);
        send_item(CH_T, 1'b0);
        send_unicode_escape(16'hFFFF);
        send_item(CH_QUOTE, 1'b0);
        send_item('0, 1'b0);
        send_unicode_escape(TWO_BYTE_MAX);
        send_unicode_escape(ONE_BYTE_MAX);
        send_end();
    endtask

    task automatic test_string_errors();
        strings_sent += 5;
        // The code zero escape.
        send_item(LETTER_A, 1'b0);
        send_unicode_escape('0);
        // A quote among the four hex positions is taken as a non-hex character.
        send_item(LETTER_A, 1'b0);
        send_item(CH_BSLASH, 1'b0);
        send_item(CH_U, 1'b0);
        send_item(hex_char(4'h1, 1'b0), 1'b0);
        send_item(CH_QUOTE, 1'b0);
        send_item(hex_char(4'hA, 1'b1), 1'b0);
        send_item(hex_char(4'hF, 1'b0), 1'b0);
        // An end mark right after a backslash.
        send_item(LETTER_A, 1'b0);
        send_item(CH_BSLASH, 1'b0);
        send_end();
        // An unknown escape letter.
        send_item(LETTER_A, 1'b0);
        send_item(CH_BSLASH, 1'b0);
        send_item(LETTER_X, 1'b0);
        // An end mark inside a short hex sequence.
        send_item(LETTER_A, 1'b0);
        send_item(CH_BSLASH, 1'b0);
        send_item(CH_U, 1'b0);
        send_item(hex_char(4'h7, 1'b0), 1'b0);
        send_end();
    endtask

    task automatic test_back_to_back();
        int stop_at;
        no_idle = 1'b1;
        stop_at = items_sent + 120;
        while (items_sent < stop_at) send_random_string();
        no_idle = 1'b0;
    endtask

    task automatic test_random_strings();
        int stop_at;
        stop_at = items_sent + RANDOM_ITEMS - 120;
        while (items_sent < stop_at) send_random_string();
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_empty_input();
        test_plain_and_unicode();
        test_string_errors();
        test_back_to_back();
        test_random_strings();
        s_tvalid <= 1'b0;
        while (expected_units.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Covered %0d input transfers in %0d strings.", items_sent, strings_sent);
        $display("Checked %0d result transfers, %0d mismatches.", units_checked, mismatches);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timeout with %0d results still expected.", expected_units.size());
        $display("Verification failed");
        $finish;
    end

endmodule

/* json_string_unescape.f */
rtl/core/jsu_pkg.sv
rtl/core/jsu_in_stage.sv
rtl/core/jsu_decode.sv
rtl/core/jsu_out_burst.sv
rtl/core/json_string_unescape.sv
tb/json_string_unescape_test.sv
